// ===== rtl/core/ufd_pkg.sv =====
// Shared types and constants for the form-encoded body decoder.
`default_nettype none
package ufd_pkg;

	localparam int DATETIME_LEN = 24;
	localparam int VLEN_W = $clog2(DATETIME_LEN + 2);
	localparam logic [VLEN_W-1:0] VLEN_MAX = VLEN_W'(DATETIME_LEN + 1);
	localparam logic [VLEN_W-1:0] VLEN_DT = VLEN_W'(DATETIME_LEN);

	localparam logic [1:0] KIND_NAME  = 2'd0;
	localparam logic [1:0] KIND_VALUE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic [3:0] VT_DROPPED  = 4'd0;
	localparam logic [3:0] VT_EMPTY    = 4'd1;
	localparam logic [3:0] VT_STRING   = 4'd2;
	localparam logic [3:0] VT_TRUE     = 4'd3;
	localparam logic [3:0] VT_FALSE    = 4'd4;
	localparam logic [3:0] VT_NULL     = 4'd5;
	localparam logic [3:0] VT_INT      = 4'd6;
	localparam logic [3:0] VT_DOUBLE   = 4'd7;
	localparam logic [3:0] VT_DATETIME = 4'd8;
	localparam logic [3:0] VT_BADSTR   = 4'd9;
	localparam logic [3:0] VT_UNKNOWN  = 4'd10;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_T_UP  = 8'h54;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam int MAX_RES = 3;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       body_end;
	} body_t;

	typedef struct packed {
		logic [1:0] item_kind;
		logic [7:0] data_byte;
		logic [3:0] value_type;
		logic       body_done;
		logic       run_last;
	} result_t;

	// results of one body byte, slot 0 goes out first
	typedef struct packed {
		logic [1:0]  cnt;
		result_t [MAX_RES-1:0] res;
	} res_set_t;

	typedef struct packed {
		logic              in_value;
		logic [1:0]        hex_phase;
		logic [3:0]        high_nibble;
		logic              bs_held;
		logic [VLEN_W-1:0] vlen;
		logic [7:0]        first_char;
		logic [7:0]        char_at_ten;
		logic              saw_dot;
		logic [7:0]        final_char;
		logic              true_match;
	} seg_t;

	localparam seg_t SEG_RESET = '{
		in_value: 1'b0, hex_phase: 2'd0, high_nibble: 4'd0, bs_held: 1'b0,
		vlen: '0, first_char: 8'd0, char_at_ten: 8'd0, saw_dot: 1'b0,
		final_char: 8'd0, true_match: 1'b1
	};

endpackage
`default_nettype wire

// ===== rtl/core/url_form_field_decoder.sv =====
// Top level of the streaming form-encoded body decoder.
// Takes one body byte per item and returns name bytes, percent-decoded and
// unquoted value bytes, and a typed segment end for each '&' or body end.
// A byte is registered, decoded in one pass, and its results (zero to three)
// land in a result register that drives one result per cycle while
// result_stall is low, so the first result of a byte is offered after the
// input register and then the result register. A byte with several results
// stalls the input until the result register is down to its last entry and
// that entry leaves. A byte with no result (the first '=', '%', a first escape
// digit, a held backslash) holds nothing up. No clearing pass after reset.
`default_nettype none
module url_form_field_decoder (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             body_valid,
	output logic                  body_stall,
	input  wire ufd_pkg::body_t   body,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output ufd_pkg::result_t      result
);
	import ufd_pkg::*;

	body_t    body_s1;
	logic     valid_s1;
	logic     free;
	logic     take;
	res_set_t res_set;

	assign take       = valid_s1 && free;
	assign body_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!body_stall) begin
			valid_s1 <= body_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body_valid && !body_stall) begin
			body_s1 <= body;
		end
	end

	ufd_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.body_s1 (body_s1),
		.res_set (res_set)
	);

	ufd_resq u_resq (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (take),
		.res_set      (res_set),
		.free         (free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== rtl/core/ufd_step.sv =====
// Segment state and the per-byte decode that builds up to three results.
`default_nettype none
module ufd_step (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire ufd_pkg::body_t  body_s1,
	output ufd_pkg::res_set_t    res_set
);
	import ufd_pkg::*;

	localparam logic [VLEN_W-1:0] IDX_TEN  = VLEN_W'(10);
	localparam logic [VLEN_W-1:0] IDX_FOUR = VLEN_W'(4);
	localparam logic [VLEN_W-1:0] IDX_ONE  = VLEN_W'(1);

	seg_t              st_q;
	seg_t              s;
	logic [1:0]        n;
	result_t [MAX_RES-1:0] res;
	logic [7:0]        d;
	logic              has_d;
	logic [7:0]        b;
	logic              is_amp;

	function automatic logic [3:0] hexv(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
		return v;
	endfunction

	function automatic logic [7:0] true_char(input logic [1:0] i);
		logic [7:0] c;
		case (i)
			2'd0:    c = CH_T;
			2'd1:    c = CH_R;
			2'd2:    c = CH_U;
			default: c = CH_E;
		endcase
		return c;
	endfunction

	function automatic seg_t emit_v(input seg_t si, input logic [7:0] u);
		seg_t so;
		so = si;
		if (si.vlen == '0) so.first_char = u;
		if (si.vlen == IDX_TEN) so.char_at_ten = u;
		so.final_char = u;
		if (u == CH_DOT) so.saw_dot = 1'b1;
		if (si.vlen >= IDX_FOUR || true_char(si.vlen[1:0]) != u) so.true_match = 1'b0;
		if (si.vlen < VLEN_MAX) so.vlen = si.vlen + IDX_ONE;
		return so;
	endfunction

	function automatic logic [3:0] resolve(input seg_t si);
		logic [3:0] t;
		if (!si.in_value) t = VT_DROPPED;
		else if (si.vlen == '0) t = VT_EMPTY;
		else if (si.first_char == CH_QUOTE)
			t = (si.vlen == IDX_ONE || si.final_char != CH_QUOTE) ? VT_BADSTR : VT_STRING;
		else if (si.first_char == CH_T || si.first_char == CH_F)
			t = (si.true_match && si.vlen == IDX_FOUR) ? VT_TRUE : VT_FALSE;
		else if (si.first_char == CH_N) t = VT_NULL;
		else if (si.first_char >= CH_0 && si.first_char <= CH_9) begin
			if (si.vlen == VLEN_DT && si.char_at_ten == CH_T_UP) t = VT_DATETIME;
			else t = si.saw_dot ? VT_DOUBLE : VT_INT;
		end else t = VT_UNKNOWN;
		return t;
	endfunction

	function automatic result_t mk(input logic [1:0] k, input logic [7:0] v,
			input logic [3:0] t, input logic dn);
		result_t r;
		r.item_kind  = k;
		r.data_byte  = v;
		r.value_type = t;
		r.body_done  = dn;
		r.run_last   = 1'b0;
		return r;
	endfunction

	always_comb begin
		s      = st_q;
		n      = 2'd0;
		res    = '0;
		d      = 8'd0;
		has_d  = 1'b0;
		b      = body_s1.body_byte;
		is_amp = (b == CH_AMP);

		if (!is_amp) begin
			if (!s.in_value) begin
				if (b == CH_EQ) s.in_value = 1'b1;
				else begin
					res[n] = mk(KIND_NAME, b, VT_DROPPED, 1'b0);
					n = n + 2'd1;
				end
			end else if (s.hex_phase == 2'd1) begin
				s.high_nibble = hexv(b);
				s.hex_phase   = 2'd2;
			end else begin
				if (s.hex_phase == 2'd2) begin
					s.hex_phase = 2'd0;
					d = {s.high_nibble, hexv(b)};
					has_d = 1'b1;
				end else if (b == CH_PCT) begin
					s.hex_phase = 2'd1;
				end else if (b == CH_PLUS) begin
					d = CH_SPACE;
					has_d = 1'b1;
				end else begin
					d = b;
					has_d = 1'b1;
				end
				// unquote stage
				if (has_d) begin
					if (s.bs_held) begin
						s.bs_held = 1'b0;
						if (d != CH_BSL && d != CH_QUOTE) begin
							s = emit_v(s, CH_BSL);
							res[n] = mk(KIND_VALUE, CH_BSL, VT_DROPPED, 1'b0);
							n = n + 2'd1;
						end
						s = emit_v(s, d);
						res[n] = mk(KIND_VALUE, d, VT_DROPPED, 1'b0);
						n = n + 2'd1;
					end else if (d == CH_BSL) begin
						s.bs_held = 1'b1;
					end else begin
						s = emit_v(s, d);
						res[n] = mk(KIND_VALUE, d, VT_DROPPED, 1'b0);
						n = n + 2'd1;
					end
				end
			end
		end

		if (is_amp || body_s1.body_end) begin
			// a backslash still held goes out before the segment end
			if (s.in_value && s.bs_held) begin
				s.bs_held = 1'b0;
				s = emit_v(s, CH_BSL);
				res[n] = mk(KIND_VALUE, CH_BSL, VT_DROPPED, 1'b0);
				n = n + 2'd1;
			end
			res[n] = mk(KIND_END, 8'd0, resolve(s), body_s1.body_end && !is_amp);
			n = n + 2'd1;
			s = SEG_RESET;
		end

		// body ending in '&': an empty segment without '=' follows
		if (is_amp && body_s1.body_end) begin
			res[n] = mk(KIND_END, 8'd0, VT_DROPPED, 1'b1);
			n = n + 2'd1;
		end

		if (n != 2'd0) res[n - 2'd1].run_last = 1'b1;

		res_set.cnt = n;
		res_set.res = res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SEG_RESET;
		end else if (take) begin
			st_q <= s;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ufd_resq.sv =====
// Result register: holds one byte's results, hands out one per unstalled cycle.
`default_nettype none
module ufd_resq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire ufd_pkg::res_set_t res_set,
	output logic                   free,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output ufd_pkg::result_t       result
);
	import ufd_pkg::*;

	logic [1:0]            cnt_q;
	result_t [MAX_RES-1:0] ent_q;
	logic                  pop;

	assign result_valid = (cnt_q != 2'd0);
	assign result       = ent_q[0];
	assign pop          = result_valid && !result_stall;
	// empty now, or the last entry leaves this cycle
	assign free         = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res_set.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= res_set.res;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ufd_checker.sv =====
// Port-level checks for the decoder and their binding to the top level.
`default_nettype none
module ufd_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire ufd_pkg::result_t result
);
	import ufd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_byte_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.item_kind != KIND_END |->
			result.value_type == VT_DROPPED && !result.body_done)
		else $error("byte item carries segment-end fields");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.item_kind == KIND_END |->
			result.data_byte == 8'd0 && result.value_type <= VT_UNKNOWN)
		else $error("bad segment end item");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.body_done |->
			result.run_last && result.item_kind == KIND_END)
		else $error("body end not the last item of its byte");

endmodule

bind url_form_field_decoder ufd_checker u_ufd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the form-encoded body decoder: directed, random and backpressure runs.
module tb_top;
	import ufd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    body_valid   = 1'b0;
	logic    body_stall;
	body_t   body         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit long_hold     = 1'b0;
	int hold_cnt      = 0;
	int cycle_cnt     = 0;
	int err_cnt       = 0;
	int sent_cnt      = 0;

	// running segment state of the bench's own decoder
	seg_t       seg = SEG_RESET;
	result_t    decode_q[$];
	logic [7:0] body_bytes[$];
	logic [7:0] specials[6] = '{CH_AMP, CH_EQ, CH_PCT, CH_PLUS, CH_BSL, CH_QUOTE};

	url_form_field_decoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.body_valid   (body_valid),
		.body_stall   (body_stall),
		.body         (body),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	function automatic logic [3:0] hex_nibble(logic [7:0] b);
		if (b >= CH_0 && b <= CH_9) return 4'(b - CH_0);
		if (b >= "a" && b <= "f") return 4'(b - "a" + 8'd10);
		if (b >= "A" && b <= "F") return 4'(b - "A" + 8'd10);
		return 4'd0;
	endfunction

	function automatic logic [7:0] true_letter(logic [1:0] idx);
		case (idx)
			2'd0: return CH_T;
			2'd1: return CH_R;
			2'd2: return CH_U;
			default: return CH_E;
		endcase
	endfunction

	function automatic void append_expected(result_t r);
		decode_q.insert(decode_q.size(), r);
	endfunction

	function automatic void append_byte(logic [7:0] c);
		body_bytes.insert(body_bytes.size(), c);
	endfunction

	function automatic void queue_result(logic [1:0] kind, logic [7:0] data, logic [3:0] vt,
			logic done);
		result_t r;
		r.item_kind  = kind;
		r.data_byte  = data;
		r.value_type = vt;
		r.body_done  = done;
		r.run_last   = 1'b0;
		append_expected(r);
	endfunction

	function automatic void add_value_byte(logic [7:0] u);
		if (seg.vlen == 0) seg.first_char = u;
		if (seg.vlen == 10) seg.char_at_ten = u;
		seg.final_char = u;
		if (u == CH_DOT) seg.saw_dot = 1'b1;
		if (seg.vlen >= 4 || true_letter(seg.vlen[1:0]) != u) seg.true_match = 1'b0;
		if (seg.vlen < VLEN_MAX) seg.vlen = seg.vlen + 1'b1;
		// value bytes carry no type
		queue_result(KIND_VALUE, u, '0, 1'b0);
	endfunction

	function automatic void unescape_byte(logic [7:0] d);
		if (seg.bs_held) begin
			seg.bs_held = 1'b0;
			if (d != CH_BSL && d != CH_QUOTE) add_value_byte(CH_BSL);
			add_value_byte(d);
		end else if (d == CH_BSL) begin
			seg.bs_held = 1'b1;
		end else begin
			add_value_byte(d);
		end
	endfunction

	function automatic logic [3:0] segment_type();
		if (!seg.in_value) return VT_DROPPED;
		if (seg.vlen == 0) return VT_EMPTY;
		if (seg.first_char == CH_QUOTE)
			return (seg.vlen == 1 || seg.final_char != CH_QUOTE) ? VT_BADSTR : VT_STRING;
		if (seg.first_char == CH_T || seg.first_char == CH_F)
			return (seg.true_match && seg.vlen == 4) ? VT_TRUE : VT_FALSE;
		if (seg.first_char == CH_N) return VT_NULL;
		if (seg.first_char >= CH_0 && seg.first_char <= CH_9) begin
			if (seg.vlen == VLEN_DT && seg.char_at_ten == CH_T_UP) return VT_DATETIME;
			return seg.saw_dot ? VT_DOUBLE : VT_INT;
		end
		return VT_UNKNOWN;
	endfunction

	function automatic void close_segment(logic done);
		// a backslash still held goes out as a plain value byte
		if (seg.in_value && seg.bs_held) begin
			seg.bs_held = 1'b0;
			add_value_byte(CH_BSL);
		end
		queue_result(KIND_END, 8'd0, segment_type(), done);
		seg = SEG_RESET;
	endfunction

	function automatic void decode_byte(body_t b);
		int      start_n;
		result_t r;
		start_n = decode_q.size();
		if (b.body_byte == CH_AMP) begin
			close_segment(1'b0);
			if (b.body_end) close_segment(1'b1);
		end else begin
			if (!seg.in_value) begin
				if (b.body_byte == CH_EQ) seg.in_value = 1'b1;
				else queue_result(KIND_NAME, b.body_byte, '0, 1'b0);
			end else if (seg.hex_phase == 2'd1) begin
				seg.high_nibble = hex_nibble(b.body_byte);
				seg.hex_phase   = 2'd2;
			end else if (seg.hex_phase == 2'd2) begin
				seg.hex_phase = 2'd0;
				unescape_byte({seg.high_nibble, hex_nibble(b.body_byte)});
			end else if (b.body_byte == CH_PCT) begin
				seg.hex_phase = 2'd1;
			end else if (b.body_byte == CH_PLUS) begin
				unescape_byte(CH_SPACE);
			end else begin
				unescape_byte(b.body_byte);
			end
			if (b.body_end) close_segment(1'b1);
		end
		if (decode_q.size() > start_n) begin
			r = decode_q.pop_back();
			r.run_last = 1'b1;
			append_expected(r);
		end
	endfunction

	// offer one item, hold it until taken, then record what it should produce
	task automatic send_item(input body_t b);
		int gap;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			gap = $urandom_range(1, 4);
			body_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		body_valid <= 1'b1;
		body       <= b;
		@(posedge clk);
		while (body_stall) @(posedge clk);
		decode_byte(b);
	endtask

	task automatic send_body();
		body_t b;
		for (int i = 0; i < body_bytes.size(); i++) begin
			b.body_byte = body_bytes[i];
			b.body_end  = (i == body_bytes.size() - 1);
			send_item(b);
			sent_cnt++;
		end
		body_bytes.delete();
	endtask

	task automatic wait_idle();
		body_valid <= 1'b0;
		while (decode_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_digit(logic [3:0] n);
		if (n < 10) return CH_0 + 8'(n);
		return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
	endfunction

	function automatic void push_value_char(logic [7:0] c);
		int r;
		r = $urandom_range(0, 99);
		if (c == CH_SPACE && r < 60) begin
			append_byte(CH_PLUS);
		end else if (c == CH_AMP || c == CH_PCT || c == CH_PLUS || r < 20) begin
			append_byte(CH_PCT);
			append_byte(hex_digit(c[7:4]));
			append_byte(hex_digit(c[3:0]));
		end else begin
			append_byte(c);
		end
	endfunction

	// value text aimed at one of the type codes, then encoded at random
	task automatic add_value();
		string txt;
		int    pick;
		txt  = "";
		pick = $urandom_range(0, 11);
		case (pick)
			1: txt = "\"ok go\"";
			2: if ($urandom_range(0, 1) != 0) txt = "\""; else txt = "\"open";
			3: txt = "true";
			4: case ($urandom_range(0, 3))
				0: txt = "false";
				1: txt = "tru";
				2: txt = "trues";
				default: txt = "f";
			endcase
			5: txt = "null";
			6: txt = $sformatf("%0d", $urandom_range(0, 99999));
			7: txt = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
			8: txt = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d+0000",
				$urandom_range(1970, 2099), $urandom_range(1, 12), $urandom_range(1, 28),
				$urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
			9: if ($urandom_range(0, 1) != 0) txt = "2001-02-03 04:05:06+0000";
				else txt = "2001-02-03T04:05:06+000";
			10: if ($urandom_range(0, 1) != 0) txt = "a&b=c%d+e"; else txt = "-1";
			default: txt = "";
		endcase
		if (pick == 11) begin
			repeat ($urandom_range(1, 6)) push_value_char(8'($urandom_range(0, 255)));
		end else begin
			for (int k = 0; k < txt.len(); k++) begin
				if ($urandom_range(0, 99) < 8) push_value_char(CH_BSL);
				push_value_char(txt[k]);
			end
		end
	endtask

	task automatic add_form_body();
		int nseg;
		nseg = $urandom_range(1, 3);
		for (int s = 0; s < nseg; s++) begin
			repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(8'h61, 8'h7A)));
			if ($urandom_range(0, 9) != 0) begin
				append_byte(CH_EQ);
				add_value();
			end
			if (s != nseg - 1 || $urandom_range(0, 9) == 0) append_byte(CH_AMP);
		end
		if (body_bytes.size() == 0) append_byte(CH_AMP);
	endtask

	task automatic add_noise_body();
		repeat ($urandom_range(1, 10)) begin
			if ($urandom_range(0, 1) != 0) append_byte(8'($urandom_range(0, 255)));
			else append_byte(specials[$urandom_range(0, 5)]);
		end
	endtask

	task automatic test_directed();
		// byte extremes in the name, bad hex digit, '+', the three backslash cases,
		// trailing backslash, truncated escape, three results from one byte
		body_bytes = '{8'h00, 8'hFF, CH_EQ, CH_PCT, "4", "g", CH_PLUS,
			CH_BSL, CH_BSL, CH_BSL, CH_QUOTE, CH_BSL, "x", CH_BSL, CH_AMP,
			"t", CH_EQ, CH_PCT, "A", CH_AMP, CH_EQ, CH_BSL, "y"};
		send_body();
		// body made of a lone '&': two dropped segment ends
		body_bytes = '{CH_AMP};
		send_body();
		wait_idle();
	endtask

	task automatic test_random_bodies(input int n_items);
		int stop_at;
		stop_at = sent_cnt + n_items;
		while (sent_cnt < stop_at) begin
			if ($urandom_range(0, 4) == 0) add_noise_body();
			else add_form_body();
			send_body();
		end
		wait_idle();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_hold     = 1'b1;
		test_random_bodies(48);
		long_hold     = 1'b0;
	endtask

	// receiver: random stalls, or one long hold-off when asked
	always @(posedge clk) begin
		if (long_hold && hold_cnt < HOLD_CYCLES) begin
			result_stall <= 1'b1;
			hold_cnt     <= hold_cnt + 1;
		end else begin
			if (!long_hold) hold_cnt <= 0;
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] actual);
		if (want_v !== actual) begin
			$error("%s: expected %0h, actual %0h", name, want_v, actual);
			err_cnt++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (decode_q.size() == 0) begin
				$error("unexpected result: item_kind %0d data_byte %0h",
					result.item_kind, result.data_byte);
				err_cnt++;
			end else begin
				want = decode_q.pop_front();
				check_field("item_kind", 8'(want.item_kind), 8'(result.item_kind));
				check_field("data_byte", want.data_byte, result.data_byte);
				check_field("value_type", 8'(want.value_type), 8'(result.value_type));
				check_field("body_done", 8'(want.body_done), 8'(result.body_done));
				check_field("run_last", 8'(want.run_last), 8'(result.run_last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 15;
		recv_idle_pct = 66;
		test_directed();
		test_random_bodies(120);
		send_idle_pct = 66;
		recv_idle_pct = 15;
		test_random_bodies(120);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_bodies(120);
		test_backpressure();
		if (err_cnt == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
